// ===== rtl/core/pft_pkg.sv =====
// Package for the plane-from-three-points pipeline: shared widths and constants.
// No dependencies.
package pft_pkg;

   localparam int PFT_COORD_WIDTH = 32;   // default coordinate width, Q16.16
   localparam int PFT_NORM_WIDTH  = 32;   // unit normal, Q2.30
   localparam int PFT_OFFS_WIDTH  = 34;   // plane offset, Q18.16
   localparam int PFT_MAG_WIDTH   = 31;   // scaled cross product magnitude
   localparam int PFT_SQ_WIDTH    = 2 * PFT_MAG_WIDTH;
   localparam int PFT_SUM_WIDTH   = 64;   // sum of three squares
   localparam int PFT_LEN_WIDTH   = PFT_SUM_WIDTH / 2;
   localparam int PFT_Q_WIDTH     = 31;   // quotient magnitude, at most 2^30
   localparam int PFT_FRAC_BITS   = 30;   // fraction bits of the normal
   localparam int PFT_NUM_WIDTH   = PFT_MAG_WIDTH + PFT_FRAC_BITS + 1;

endpackage

// ===== rtl/core/pft_req_if.sv =====
// Request channel: three points in signed Q16.16.
// Depends on pft_pkg.
interface pft_req_if import pft_pkg::*; #(
   parameter int COORD_WIDTH = PFT_COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic signed [COORD_WIDTH-1:0] first_z;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;
   logic signed [COORD_WIDTH-1:0] second_z;
   logic signed [COORD_WIDTH-1:0] third_x;
   logic signed [COORD_WIDTH-1:0] third_y;
   logic signed [COORD_WIDTH-1:0] third_z;

   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   third_x, third_y, third_z, input ready);
   modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   third_x, third_y, third_z, output ready);
endinterface

// ===== rtl/core/pft_rsp_if.sv =====
// Response channel: unit normal, plane offset and degenerate flag.
// Depends on pft_pkg.
interface pft_rsp_if import pft_pkg::*;;
   logic                             valid;
   logic                             ready;
   logic signed [PFT_NORM_WIDTH-1:0] normal_x;
   logic signed [PFT_NORM_WIDTH-1:0] normal_y;
   logic signed [PFT_NORM_WIDTH-1:0] normal_z;
   logic signed [PFT_OFFS_WIDTH-1:0] plane_offset;
   logic                             degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, plane_offset, degenerate,
                   input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, plane_offset, degenerate,
                   output ready);
endinterface

// ===== rtl/core/plane_from_three_points.sv =====
// Top level: plane through three points, unit normal and offset.
// Depends on pft_pkg, pft_req_if, pft_rsp_if, pft_cross, pft_norm, pft_sqrt, pft_div.
//
//  channel   | dir | payload                                    | format
//  ----------+-----+--------------------------------------------+---------------------
//  req_chan  | in  | first/second/third _x/_y/_z                | signed Q16.16 each
//  rsp_chan  | out | normal_x/y/z, plane_offset, degenerate     | Q2.30, Q18.16, flag
//
//  One request accepted per cycle while no response waits untaken at the output register;
//  each gives one response after the cross product, scaling, square root, divider and offset stages.
//  Latency is set by the bit-per-stage square root and divider.
//  Reset (synchronous) clears the valid bits only; payload registers are not reset.
//  One enable moves every stage: the pipeline halts as a whole while a response
//  waits at the output register and is not taken, so nothing is lost or repeated.
module plane_from_three_points import pft_pkg::*; #(
   parameter int COORD_WIDTH = PFT_COORD_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   pft_req_if.sink      req_chan,
   pft_rsp_if.source    rsp_chan
);
   localparam int CW    = COORD_WIDTH;
   localparam int CXW   = 2 * CW + 3;              // cross product component
   localparam int SIDE  = 3 + 3 * CW;               // signs and first point
   localparam int T_SQ  = 1 + 3 * PFT_MAG_WIDTH + SIDE;
   localparam int T_DV  = 1 + SIDE;
   localparam int PRW   = PFT_NORM_WIDTH + CW;      // normal times coordinate
   localparam int AW    = PRW + 3;                  // offset accumulator, Q.46
   localparam int SHW   = AW - PFT_FRAC_BITS;
   localparam int SW    = (SHW > PFT_OFFS_WIDTH) ? SHW : PFT_OFFS_WIDTH;

   localparam logic signed [SW-1:0] OFF_HI = SW'((64'sd1 <<< (PFT_OFFS_WIDTH - 1)) - 1);
   localparam logic signed [SW-1:0] OFF_LO = -SW'(64'sd1 <<< (PFT_OFFS_WIDTH - 1));
   localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (PFT_FRAC_BITS - 1));

   // global advance: the output register is empty or being drained
   logic en;
   logic out_vld_ff;

   assign en             = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // ---------------- front end: edges and cross product ----------------
   logic signed [CW-1:0] p1 [3];
   logic signed [CW-1:0] p2 [3];
   logic signed [CW-1:0] p3 [3];

   assign p1[0] = req_chan.first_x;
   assign p1[1] = req_chan.first_y;
   assign p1[2] = req_chan.first_z;
   assign p2[0] = req_chan.second_x;
   assign p2[1] = req_chan.second_y;
   assign p2[2] = req_chan.second_z;
   assign p3[0] = req_chan.third_x;
   assign p3[1] = req_chan.third_y;
   assign p3[2] = req_chan.third_z;

   logic                 cx_vld;
   logic [CXW-1:0]       cx_mag [3];
   logic [2:0]           cx_neg;
   logic [3*CW-1:0]      cx_p1;

   pft_cross #(.CW(CW), .TW(3 * CW)) u_cross (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_chan.valid && en),
      .p1      (p1),
      .p2      (p2),
      .p3      (p3),
      .tag_in  ({p1[2], p1[1], p1[0]}),
      .out_vld (cx_vld),
      .mag     (cx_mag),
      .neg     (cx_neg),
      .tag_out (cx_p1)
   );

   // ---------------- scaling and sum of squares ----------------
   logic                      nm_vld;
   logic [PFT_MAG_WIDTH-1:0]  nm_m [3];
   logic [PFT_SUM_WIDTH-1:0]  nm_sum;
   logic                      nm_deg;
   logic [SIDE-1:0]           nm_side;

   pft_norm #(.CXW(CXW), .TW(SIDE)) u_norm (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (cx_vld),
      .mag     (cx_mag),
      .tag_in  ({cx_neg, cx_p1}),
      .out_vld (nm_vld),
      .m       (nm_m),
      .sum     (nm_sum),
      .deg     (nm_deg),
      .tag_out (nm_side)
   );

   // ---------------- vector length ----------------
   logic                      sq_vld;
   logic [PFT_LEN_WIDTH-1:0]  sq_len;
   logic [T_SQ-1:0]           sq_tag;
   logic [PFT_MAG_WIDTH-1:0]  sq_m [3];
   logic                      sq_deg;
   logic [SIDE-1:0]           sq_side;

   pft_sqrt #(.TW(T_SQ)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (nm_vld),
      .val     (nm_sum),
      .tag_in  ({nm_deg, nm_m[2], nm_m[1], nm_m[0], nm_side}),
      .out_vld (sq_vld),
      .root    (sq_len),
      .tag_out (sq_tag)
   );

   assign sq_side = sq_tag[SIDE-1:0];
   assign sq_m[0] = sq_tag[SIDE +: PFT_MAG_WIDTH];
   assign sq_m[1] = sq_tag[SIDE + PFT_MAG_WIDTH +: PFT_MAG_WIDTH];
   assign sq_m[2] = sq_tag[SIDE + 2 * PFT_MAG_WIDTH +: PFT_MAG_WIDTH];
   assign sq_deg  = sq_tag[T_SQ-1];

   // ---------------- normalising divide ----------------
   // a zero length only comes with the degenerate flag, whose result is forced to zero
   logic                    dv_vld;
   logic [PFT_Q_WIDTH-1:0]  dv_q [3];
   logic [T_DV-1:0]         dv_tag;

   pft_div #(.TW(T_DV)) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (sq_vld),
      .len     (sq_len),
      .m       (sq_m),
      .tag_in  ({sq_deg, sq_side}),
      .out_vld (dv_vld),
      .quo     (dv_q),
      .tag_out (dv_tag)
   );

   // ---------------- signs, offset and output ----------------
   logic [2:0]                       f_vld_ff;
   logic signed [PFT_NORM_WIDTH-1:0] nrm_ff [3][3];
   logic signed [CW-1:0]             fp1_ff [3];
   logic [2:0]                       fdeg_ff;
   logic signed [PRW-1:0]            pr_ff [3];
   logic signed [AW-1:0]             acc_ff;

   logic signed [PFT_NORM_WIDTH-1:0] normal_x_ff;
   logic signed [PFT_NORM_WIDTH-1:0] normal_y_ff;
   logic signed [PFT_NORM_WIDTH-1:0] normal_z_ff;
   logic signed [PFT_OFFS_WIDTH-1:0] offset_ff;
   logic                             deg_ff;
   logic signed [PFT_OFFS_WIDTH-1:0] offset_in;

   // round-half-up shift out of Q.46, then clamp to the 34-bit range
   always_comb begin
      logic signed [SHW-1:0] shr;
      logic signed [SW-1:0]  ext;
      shr = acc_ff[AW-1:PFT_FRAC_BITS];
      ext = SW'(shr);
      if (ext > OFF_HI)      offset_in = PFT_OFFS_WIDTH'(OFF_HI);
      else if (ext < OFF_LO) offset_in = PFT_OFFS_WIDTH'(OFF_LO);
      else                   offset_in = PFT_OFFS_WIDTH'(ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff   <= {f_vld_ff[1:0], dv_vld};
         out_vld_ff <= f_vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // sign back on; degenerate points give a zero normal and so a zero offset
         for (int i = 0; i < 3; i++) begin
            if (dv_tag[T_DV-1])
               nrm_ff[0][i] <= '0;
            else if (dv_tag[3 * CW + i])
               nrm_ff[0][i] <= -PFT_NORM_WIDTH'(dv_q[i]);
            else
               nrm_ff[0][i] <= PFT_NORM_WIDTH'(dv_q[i]);
            fp1_ff[i] <= dv_tag[i * CW +: CW];
         end
         fdeg_ff  <= {fdeg_ff[1:0], dv_tag[T_DV-1]};
         nrm_ff[1] <= nrm_ff[0];
         nrm_ff[2] <= nrm_ff[1];
         for (int i = 0; i < 3; i++) pr_ff[i] <= nrm_ff[0][i] * fp1_ff[i];
         acc_ff <= HALF - (AW'(pr_ff[0]) + AW'(pr_ff[1]) + AW'(pr_ff[2]));
         normal_x_ff <= nrm_ff[2][0];
         normal_y_ff <= nrm_ff[2][1];
         normal_z_ff <= nrm_ff[2][2];
         offset_ff   <= offset_in;
         deg_ff      <= fdeg_ff[2];
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.normal_x     = normal_x_ff;
   assign rsp_chan.normal_y     = normal_y_ff;
   assign rsp_chan.normal_z     = normal_z_ff;
   assign rsp_chan.plane_offset = offset_ff;
   assign rsp_chan.degenerate   = deg_ff;

endmodule

// ===== rtl/core/pft_cross.sv =====
// Edge vectors, cross product and magnitudes: four register stages.
// Depends on pft_pkg.
module pft_cross import pft_pkg::*; #(
   parameter int CW = PFT_COORD_WIDTH,
   parameter int TW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  logic signed [CW-1:0]   p1 [3],
   input  logic signed [CW-1:0]   p2 [3],
   input  logic signed [CW-1:0]   p3 [3],
   input  logic [TW-1:0]          tag_in,
   output logic                   out_vld,
   output logic [2*CW+2:0]        mag [3],
   output logic [2:0]             neg,
   output logic [TW-1:0]          tag_out
);
   localparam int EW  = CW + 1;
   localparam int PW  = 2 * EW;
   localparam int CXW = PW + 1;

   logic [3:0]             vld_ff;
   logic [TW-1:0]          tag_ff [4];
   logic signed [EW-1:0]   e1_ff [3];
   logic signed [EW-1:0]   e2_ff [3];
   logic signed [PW-1:0]   prod_ff [6];
   logic signed [CXW-1:0]  c_ff [3];
   logic [CXW-1:0]         mag_ff [3];
   logic [2:0]             neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= tag_in;
         for (int s = 1; s < 4; s++) tag_ff[s] <= tag_ff[s-1];
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= EW'(p2[i]) - EW'(p1[i]);
            e2_ff[i] <= EW'(p3[i]) - EW'(p1[i]);
         end
         prod_ff[0] <= e1_ff[1] * e2_ff[2];
         prod_ff[1] <= e1_ff[2] * e2_ff[1];
         prod_ff[2] <= e1_ff[2] * e2_ff[0];
         prod_ff[3] <= e1_ff[0] * e2_ff[2];
         prod_ff[4] <= e1_ff[0] * e2_ff[1];
         prod_ff[5] <= e1_ff[1] * e2_ff[0];
         for (int i = 0; i < 3; i++) begin
            c_ff[i]   <= CXW'(prod_ff[2*i]) - CXW'(prod_ff[2*i+1]);
            neg_ff[i] <= c_ff[i][CXW-1];
            mag_ff[i] <= c_ff[i][CXW-1] ? -c_ff[i] : c_ff[i];
         end
      end
   end

   assign out_vld = vld_ff[3];
   assign mag     = mag_ff;
   assign neg     = neg_ff;
   assign tag_out = tag_ff[3];

endmodule

// ===== rtl/core/pft_norm.sv =====
// Scales the cross product to a 31-bit top magnitude and sums the squares.
// Four register stages. Depends on pft_pkg.
module pft_norm import pft_pkg::*; #(
   parameter int CXW = 67,
   parameter int TW  = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic [CXW-1:0]            mag [3],
   input  logic [TW-1:0]             tag_in,
   output logic                      out_vld,
   output logic [PFT_MAG_WIDTH-1:0]  m [3],
   output logic [PFT_SUM_WIDTH-1:0]  sum,
   output logic                      deg,
   output logic [TW-1:0]             tag_out
);
   localparam int LW = $clog2(CXW + 1);
   localparam logic [LW-1:0] TOP = LW'(PFT_MAG_WIDTH);

   logic [3:0]                vld_ff;
   logic [TW-1:0]             tag_ff [4];
   logic [CXW-1:0]            mag_ff [3];
   logic [LW-1:0]             bl_ff;
   logic [LW-1:0]             bl_in;
   logic [PFT_MAG_WIDTH-1:0]  m_ff [3][3];
   logic [PFT_MAG_WIDTH-1:0]  m_in [3];
   logic [PFT_SQ_WIDTH-1:0]   sq_ff [3];
   logic [PFT_SUM_WIDTH-1:0]  sum_ff;
   logic [2:0]                deg_ff;

   always_comb begin
      logic [CXW-1:0] orv;
      orv   = mag[0] | mag[1] | mag[2];
      bl_in = '0;
      for (int b = 0; b < CXW; b++) begin
         if (orv[b]) bl_in = LW'(b + 1);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (bl_ff > TOP) m_in[i] = PFT_MAG_WIDTH'(mag_ff[i] >> (bl_ff - TOP));
         else             m_in[i] = PFT_MAG_WIDTH'(mag_ff[i] << (TOP - bl_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= tag_in;
         for (int s = 1; s < 4; s++) tag_ff[s] <= tag_ff[s-1];
         mag_ff <= mag;
         bl_ff  <= bl_in;
         deg_ff <= {deg_ff[1:0], bl_ff == '0};
         m_ff[0] <= m_in;
         m_ff[1] <= m_ff[0];
         m_ff[2] <= m_ff[1];
         for (int i = 0; i < 3; i++) sq_ff[i] <= m_ff[0][i] * m_ff[0][i];
         sum_ff <= PFT_SUM_WIDTH'(sq_ff[0]) + PFT_SUM_WIDTH'(sq_ff[1])
                 + PFT_SUM_WIDTH'(sq_ff[2]);
      end
   end

   assign out_vld = vld_ff[3];
   assign m       = m_ff[2];
   assign sum     = sum_ff;
   assign deg     = deg_ff[2];
   assign tag_out = tag_ff[3];

endmodule

// ===== rtl/core/pft_sqrt.sv =====
// Pipelined integer square root, one result bit per stage (32 stages).
// Depends on pft_pkg.
module pft_sqrt import pft_pkg::*; #(
   parameter int TW = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic [PFT_SUM_WIDTH-1:0]  val,
   input  logic [TW-1:0]             tag_in,
   output logic                      out_vld,
   output logic [PFT_LEN_WIDTH-1:0]  root,
   output logic [TW-1:0]             tag_out
);
   localparam int STEPS = PFT_LEN_WIDTH;
   localparam int TRW   = PFT_SUM_WIDTH + 2;

   logic [STEPS-1:0]          vld_ff;
   logic [PFT_SUM_WIDTH-1:0]  rem_ff  [STEPS];
   logic [PFT_LEN_WIDTH-1:0]  root_ff [STEPS];
   logic [TW-1:0]             tag_ff  [STEPS];

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int K = STEPS - 1 - j;
      logic [PFT_SUM_WIDTH-1:0] rem_i;
      logic [PFT_LEN_WIDTH-1:0] root_i;
      logic [TW-1:0]            tag_i;
      logic                     vld_i;
      logic [TRW-1:0]           trial;

      if (j == 0) begin : g_first
         assign rem_i  = val;
         assign root_i = '0;
         assign tag_i  = tag_in;
         assign vld_i  = in_vld;
      end else begin : g_next
         assign rem_i  = rem_ff[j-1];
         assign root_i = root_ff[j-1];
         assign tag_i  = tag_ff[j-1];
         assign vld_i  = vld_ff[j-1];
      end

      // root holds only bits above K, so the OR is an add
      assign trial = (TRW'(root_i) << (K + 1)) | (TRW'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[j] <= tag_i;
            if (TRW'(rem_i) >= trial) begin
               rem_ff[j]  <= PFT_SUM_WIDTH'(TRW'(rem_i) - trial);
               root_ff[j] <= root_i | (PFT_LEN_WIDTH'(1) << K);
            end else begin
               rem_ff[j]  <= rem_i;
               root_ff[j] <= root_i;
            end
         end
      end
   end

   assign out_vld = vld_ff[STEPS-1];
   assign root    = root_ff[STEPS-1];
   assign tag_out = tag_ff[STEPS-1];

endmodule

// ===== rtl/core/pft_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor.
// One quotient bit per stage (31 stages), rounded to nearest. Depends on pft_pkg.
module pft_div import pft_pkg::*; #(
   parameter int TW = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic [PFT_LEN_WIDTH-1:0]  len,
   input  logic [PFT_MAG_WIDTH-1:0]  m [3],
   input  logic [TW-1:0]             tag_in,
   output logic                      out_vld,
   output logic [PFT_Q_WIDTH-1:0]    quo [3],
   output logic [TW-1:0]             tag_out
);
   localparam int STEPS = PFT_Q_WIDTH;
   localparam int NW    = PFT_NUM_WIDTH;

   logic [STEPS-1:0]          vld_ff;
   logic [NW-1:0]             rem_ff [STEPS][3];
   logic [PFT_Q_WIDTH-1:0]    q_ff   [STEPS][3];
   logic [PFT_LEN_WIDTH-1:0]  len_ff [STEPS];
   logic [TW-1:0]             tag_ff [STEPS];

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int K = STEPS - 1 - j;
      logic [NW-1:0]            rem_i [3];
      logic [PFT_Q_WIDTH-1:0]   q_i   [3];
      logic [PFT_LEN_WIDTH-1:0] len_i;
      logic [TW-1:0]            tag_i;
      logic                     vld_i;
      logic [NW-1:0]            dsr;

      if (j == 0) begin : g_first
         // numerator m * 2^30 + len / 2
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_i[i] = (NW'(m[i]) << PFT_FRAC_BITS) + NW'(len >> 1);
            assign q_i[i]   = '0;
         end
         assign len_i = len;
         assign tag_i = tag_in;
         assign vld_i = in_vld;
      end else begin : g_next
         assign rem_i = rem_ff[j-1];
         assign q_i   = q_ff[j-1];
         assign len_i = len_ff[j-1];
         assign tag_i = tag_ff[j-1];
         assign vld_i = vld_ff[j-1];
      end

      assign dsr = NW'(len_i) << K;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[j] <= tag_i;
            len_ff[j] <= len_i;
            for (int i = 0; i < 3; i++) begin
               if (rem_i[i] >= dsr) begin
                  rem_ff[j][i] <= rem_i[i] - dsr;
                  q_ff[j][i]   <= q_i[i] | (PFT_Q_WIDTH'(1) << K);
               end else begin
                  rem_ff[j][i] <= rem_i[i];
                  q_ff[j][i]   <= q_i[i];
               end
            end
         end
      end
   end

   assign out_vld = vld_ff[STEPS-1];
   assign quo     = q_ff[STEPS-1];
   assign tag_out = tag_ff[STEPS-1];

endmodule
